/* sv/fpr_pkg.sv */
// ----------------------------------------------------------------------------
// Fast-packet reassembly package
// Shared constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int SLOT_COUNT_DEF        = 128;
  localparam int FRAMES_PER_PACKET_DEF = 32;
  localparam int FIRST_CHUNK_BYTES     = 6;
  localparam int NEXT_CHUNK_BYTES      = 7;
  localparam int MASK_W                = 32;
  // floor(x / 7) == (x * 293) >> 11 for every 8-bit x
  localparam int DIV7_MUL              = 293;
  localparam int DIV7_SHIFT            = 11;

  localparam logic [1:0] ST_PENDING     = 2'd0;
  localparam logic [1:0] ST_PENDING_DUP = 2'd1;
  localparam logic [1:0] ST_DROPPED     = 2'd2;
  localparam logic [1:0] ST_COMPLETE    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_EMIT,
    S_TAIL
  } fpr_state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan;
    logic fetch;
    logic update;
    logic emit_start;
    logic emit;
    logic drop_out;
    logic pend_out;
  } fpr_cmd_t;

  typedef struct packed {
    logic idx_bad;
    logic scan_end;
    logic found;
    logic complete;
    logic f_last;
  } fpr_stat_t;

  typedef struct packed {
    logic [17:0]       group;
    logic [7:0]        source;
    logic [MASK_W-1:0] received;
    logic [MASK_W-1:0] expected;
    logic [7:0]        length;
  } fpr_slot_t;

endpackage

/* sv/fpr_ctrl.sv */
// ----------------------------------------------------------------------------
// Fast-packet reassembly controller
// Sequences slot search, slot update and chunk read-out for one request.
// ----------------------------------------------------------------------------
module fpr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fpr_pkg::fpr_stat_t stat,
  output fpr_pkg::fpr_cmd_t  cmd,
  output logic              busy
);

  fpr_pkg::fpr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fpr_pkg::S_IDLE: begin
        if (start) state_next = fpr_pkg::S_CHECK;
      end
      fpr_pkg::S_CHECK: begin
        state_next = stat.idx_bad ? fpr_pkg::S_IDLE : fpr_pkg::S_SCAN;
      end
      fpr_pkg::S_SCAN: begin
        if (stat.scan_end) state_next = fpr_pkg::S_DECIDE;
      end
      fpr_pkg::S_DECIDE: begin
        state_next = stat.found ? fpr_pkg::S_UPDATE : fpr_pkg::S_IDLE;
      end
      fpr_pkg::S_UPDATE: begin
        state_next = stat.complete ? fpr_pkg::S_EMIT : fpr_pkg::S_IDLE;
      end
      fpr_pkg::S_EMIT: begin
        if (stat.f_last) state_next = fpr_pkg::S_TAIL;
      end
      fpr_pkg::S_TAIL: begin
        state_next = fpr_pkg::S_IDLE;
      end
      default: begin
        state_next = fpr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      fpr_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      fpr_pkg::S_CHECK: begin
        cmd.drop_out   = stat.idx_bad;
        cmd.scan_start = !stat.idx_bad;
      end
      fpr_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      fpr_pkg::S_DECIDE: begin
        cmd.fetch    = stat.found;
        cmd.drop_out = !stat.found;
      end
      fpr_pkg::S_UPDATE: begin
        cmd.update     = 1'b1;
        cmd.pend_out   = !stat.complete;
        cmd.emit_start = stat.complete;
      end
      fpr_pkg::S_EMIT: begin
        cmd.emit = 1'b1;
      end
      fpr_pkg::S_TAIL: begin
        cmd = '0;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* sv/fpr_datapath.sv */
// ----------------------------------------------------------------------------
// Fast-packet reassembly datapath
// Slot table and chunk store memories, key scan, slot update and result regs.
// ----------------------------------------------------------------------------
module fpr_datapath #(
  parameter int SLOT_COUNT        = fpr_pkg::SLOT_COUNT_DEF,
  parameter int FRAMES_PER_PACKET = fpr_pkg::FRAMES_PER_PACKET_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  fpr_pkg::fpr_cmd_t  cmd,
  output fpr_pkg::fpr_stat_t stat,
  input  logic [17:0]        group_number,
  input  logic [7:0]         source_address,
  input  logic [63:0]        frame_bytes,
  output logic               strobe,
  output logic [1:0]         status,
  output logic [6:0]         slot_number,
  output logic [17:0]        packet_group,
  output logic [7:0]         packet_source,
  output logic [7:0]         packet_size,
  output logic [4:0]         chunk_index,
  output logic [55:0]        chunk_data,
  output logic [2:0]         chunk_bytes,
  output logic               last_chunk
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FW = $clog2(FRAMES_PER_PACKET);
  localparam int AW = $clog2(SLOT_COUNT * FRAMES_PER_PACKET);
  localparam int MW = fpr_pkg::MASK_W;

  // latched request
  logic [17:0] grp;
  logic [7:0]  src;
  logic [63:0] fb;

  fpr_pkg::fpr_slot_t slot_mem [SLOT_COUNT];
  fpr_pkg::fpr_slot_t slot_q;
  logic [55:0]        chunk_mem [SLOT_COUNT * FRAMES_PER_PACKET];
  logic [55:0]        chunk_q;

  logic [SLOT_COUNT-1:0] slot_busy;
  logic [SLOT_COUNT-1:0] len_valid;

  logic [SW-1:0] cnt, rd_idx, sel, free_idx, chosen, rd_addr;
  logic          rd_vld, hit, free_found, claimed;
  logic          hit_now;

  logic [FW-1:0] f, ch_f;
  logic          ch_vld;
  logic [MW-1:0] emit_mask;
  logic [7:0]    pk_len;

  // update path
  logic [4:0]         fidx;
  logic [MW-1:0]      bitm, rec0, rec1, rec2, exp_old, exp_new;
  logic [7:0]         len_old, len_new;
  logic               dup, load_len, complete;
  logic [16:0]        prod;
  logic [5:0]         shift;
  logic [55:0]        chunk_new;
  logic [AW-1:0]      wr_addr, ch_addr;
  fpr_pkg::fpr_slot_t slot_new;

  assign fidx    = fb[4:0];
  assign chosen  = hit ? sel : free_idx;
  assign rd_addr = cmd.fetch ? chosen : cnt;
  assign hit_now = rd_vld && slot_busy[rd_idx] && slot_q.group == grp && slot_q.source == src;

  always_comb begin
    stat.idx_bad  = {1'b0, fidx} >= 6'(FRAMES_PER_PACKET);
    stat.scan_end = rd_vld && (hit_now || rd_idx == SW'(SLOT_COUNT - 1));
    stat.found    = hit || free_found;
    stat.complete = complete;
    stat.f_last   = f == FW'(FRAMES_PER_PACKET - 1);
  end

  always_comb begin
    bitm     = MW'(1) << fidx;
    rec0     = claimed ? '0 : slot_q.received;
    exp_old  = len_valid[sel] ? slot_q.expected : '0;
    len_old  = len_valid[sel] ? slot_q.length : '0;
    dup      = |(rec0 & bitm);
    rec1     = dup ? '0 : rec0;
    load_len = (fidx == 5'd0) && (rec1 == '0);
    prod     = 17'(fb[15:8]) * 17'(fpr_pkg::DIV7_MUL);
    shift    = 6'(prod[16:fpr_pkg::DIV7_SHIFT]) + 6'd1;
    len_new  = load_len ? fb[15:8] : len_old;
    exp_new  = !load_len ? exp_old :
               (shift >= 6'(MW)) ? '1 : ((MW'(1) << shift) - MW'(1));
    rec2     = rec1 | bitm;
    complete = rec2 == exp_new;
    chunk_new = (fidx == 5'd0) ? {8'd0, fb[63:16]} : fb[63:8];
    slot_new.group    = grp;
    slot_new.source   = src;
    slot_new.received = complete ? '0 : rec2;
    slot_new.expected = exp_new;
    slot_new.length   = len_new;
    wr_addr = AW'(sel) * AW'(FRAMES_PER_PACKET) + AW'(fidx);
    ch_addr = AW'(sel) * AW'(FRAMES_PER_PACKET) + AW'(f);
  end

  always_ff @(posedge clk) begin
    slot_q <= slot_mem[rd_addr];
    if (cmd.update) slot_mem[sel] <= slot_new;
  end

  always_ff @(posedge clk) begin
    chunk_q <= chunk_mem[ch_addr];
    if (cmd.update) chunk_mem[wr_addr] <= chunk_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      grp <= group_number;
      src <= source_address;
      fb  <= frame_bytes;
    end
    if (cmd.scan_start) cnt <= '0;
    if (cmd.scan) begin
      cnt    <= (cnt == SW'(SLOT_COUNT - 1)) ? '0 : cnt + SW'(1);
      rd_idx <= cnt;
      if (hit_now) sel <= rd_idx;
      if (rd_vld && !slot_busy[rd_idx] && !free_found) free_idx <= rd_idx;
    end
    if (cmd.fetch) begin
      sel     <= chosen;
      claimed <= !hit;
    end
    if (cmd.update) begin
      emit_mask <= rec2;
      pk_len    <= len_new;
    end
    if (cmd.emit_start) f <= '0;
    if (cmd.emit) begin
      f    <= f + FW'(1);
      ch_f <= f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      ch_vld     <= 1'b0;
      slot_busy  <= '0;
      len_valid  <= '0;
    end else begin
      ch_vld <= cmd.emit;
      if (cmd.scan_start) begin
        rd_vld     <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end
      if (cmd.scan) begin
        rd_vld <= 1'b1;
        if (hit_now) hit <= 1'b1;
        if (rd_vld && !slot_busy[rd_idx]) free_found <= 1'b1;
      end
      if (cmd.update) begin
        slot_busy[sel] <= !complete;
        len_valid[sel] <= 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.drop_out || cmd.pend_out || (ch_vld && emit_mask[ch_f]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drop_out) begin
      status        <= fpr_pkg::ST_DROPPED;
      slot_number   <= '0;
      packet_group  <= '0;
      packet_source <= '0;
      packet_size   <= '0;
      chunk_index   <= '0;
      chunk_data    <= '0;
      chunk_bytes   <= '0;
      last_chunk    <= 1'b1;
    end else if (cmd.pend_out) begin
      status        <= dup ? fpr_pkg::ST_PENDING_DUP : fpr_pkg::ST_PENDING;
      slot_number   <= 7'(sel);
      packet_group  <= grp;
      packet_source <= src;
      packet_size   <= len_new;
      chunk_index   <= '0;
      chunk_data    <= '0;
      chunk_bytes   <= '0;
      last_chunk    <= 1'b1;
    end else if (ch_vld) begin
      status        <= fpr_pkg::ST_COMPLETE;
      slot_number   <= 7'(sel);
      packet_group  <= grp;
      packet_source <= src;
      packet_size   <= pk_len;
      chunk_index   <= 5'(ch_f);
      chunk_data    <= chunk_q;
      chunk_bytes   <= (ch_f == '0) ? 3'(fpr_pkg::FIRST_CHUNK_BYTES)
                                    : 3'(fpr_pkg::NEXT_CHUNK_BYTES);
      last_chunk    <= ((emit_mask >> ch_f) >> 1) == '0;
    end
  end

endmodule

/* sv/fast_packet_reassembly_top.sv */
// ----------------------------------------------------------------------------
// Fast-packet reassembly top level
// Reassembles multi-frame CAN packets keyed by group number and source.
// ----------------------------------------------------------------------------
// Usage: drive group_number, source_address and frame_bytes and raise start;
// the request is taken on an edge where start is high and busy is low.
// Results come out on the result ports, each valid for exactly one cycle
// while strobe is high; last_chunk marks the final result of a request.
// The receiver cannot stall, so nothing holds results back.
// Sequence: a check state, then a linear slot search at one slot per cycle
// through the slot table memory, ending early on a key match, then a decide
// state and an update state. A pending or dropped result appears on the
// cycle after the request ends. A completed packet then reads its chunk
// store row one chunk a cycle. A frame with a bad index is dropped in the
// check state. Reset clears all slot busy flags at once; chunk store needs
// no clearing.
// ----------------------------------------------------------------------------
module fast_packet_reassembly_top #(
  parameter int SLOT_COUNT        = fpr_pkg::SLOT_COUNT_DEF,
  parameter int FRAMES_PER_PACKET = fpr_pkg::FRAMES_PER_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [17:0] group_number,
  input  logic [7:0]  source_address,
  input  logic [63:0] frame_bytes,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [6:0]  slot_number,
  output logic [17:0] packet_group,
  output logic [7:0]  packet_source,
  output logic [7:0]  packet_size,
  output logic [4:0]  chunk_index,
  output logic [55:0] chunk_data,
  output logic [2:0]  chunk_bytes,
  output logic        last_chunk
);

  fpr_pkg::fpr_cmd_t  cmd;
  fpr_pkg::fpr_stat_t stat;

  fpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fpr_datapath #(
    .SLOT_COUNT        (SLOT_COUNT),
    .FRAMES_PER_PACKET (FRAMES_PER_PACKET)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .group_number   (group_number),
    .source_address (source_address),
    .frame_bytes    (frame_bytes),
    .strobe         (strobe),
    .status         (status),
    .slot_number    (slot_number),
    .packet_group   (packet_group),
    .packet_source  (packet_source),
    .packet_size    (packet_size),
    .chunk_index    (chunk_index),
    .chunk_data     (chunk_data),
    .chunk_bytes    (chunk_bytes),
    .last_chunk     (last_chunk)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Fast-packet reassembly testbench
// Sends CAN fast-packet frames through the reassembly block, tracks the slot
// table and chunk store in a local model and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS      = 128;
  localparam int FRAMES     = 32;
  localparam int CYCLE_CAP  = 1000000;
  localparam int TAIL_WAIT  = 200;

  typedef struct {
    logic [1:0]  status;
    logic [6:0]  slot;
    logic [17:0] group;
    logic [7:0]  source;
    logic [7:0]  size;
    logic [4:0]  index;
    logic [55:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } frag_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [17:0] group_number = '0;
  logic [7:0]  source_address = '0;
  logic [63:0] frame_bytes = '0;
  logic        strobe;
  logic [1:0]  status;
  logic [6:0]  slot_number;
  logic [17:0] packet_group;
  logic [7:0]  packet_source;
  logic [7:0]  packet_size;
  logic [4:0]  chunk_index;
  logic [55:0] chunk_data;
  logic [2:0]  chunk_bytes;
  logic        last_chunk;

  // local copy of the slot table
  logic        tbl_busy [SLOTS];
  logic [17:0] tbl_group [SLOTS];
  logic [7:0]  tbl_source [SLOTS];
  logic [31:0] tbl_rx [SLOTS];
  logic [31:0] tbl_want [SLOTS];
  logic [7:0]  tbl_len [SLOTS];
  logic [55:0] chunk_mem [SLOTS][FRAMES];

  frag_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int frames_sent = 0;
  int packets_done = 0;
  int drops_seen = 0;
  int restarts_seen = 0;

  fast_packet_reassembly_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .group_number(group_number), .source_address(source_address),
    .frame_bytes(frame_bytes), .strobe(strobe), .status(status),
    .slot_number(slot_number), .packet_group(packet_group),
    .packet_source(packet_source), .packet_size(packet_size),
    .chunk_index(chunk_index), .chunk_data(chunk_data),
    .chunk_bytes(chunk_bytes), .last_chunk(last_chunk)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic frag_result_t mk_result(logic [1:0] st, int s, logic [4:0] idx,
                                             logic [55:0] d, logic [2:0] nb, logic l);
    frag_result_t r;
    r.status = st;
    r.slot   = s[6:0];
    r.group  = tbl_group[s];
    r.source = tbl_source[s];
    r.size   = tbl_len[s];
    r.index  = idx;
    r.data   = d;
    r.nbytes = nb;
    r.last   = l;
    return r;
  endfunction

  // Works out the results of one accepted frame and updates the slot table.
  function automatic void reassemble(logic [17:0] g, logic [7:0] src, logic [63:0] fb);
    int s;
    int f;
    int last_f;
    logic [4:0] idx;
    logic [1:0] st;
    logic [31:0] shift;
    frag_result_t r;
    idx = fb[4:0];
    st = fpr_pkg::ST_PENDING;
    s = -1;
    for (int k = 0; k < SLOTS; k++)
      if (s < 0 && tbl_busy[k] && tbl_group[k] == g && tbl_source[k] == src) s = k;
    if (s < 0) begin
      for (int k = 0; k < SLOTS; k++)
        if (s < 0 && !tbl_busy[k]) s = k;
      if (s < 0) begin
        r = '{fpr_pkg::ST_DROPPED, '0, '0, '0, '0, '0, '0, '0, 1'b1};
        pending_results.push_back(r);
        return;
      end
      tbl_busy[s] = 1'b1;
      tbl_group[s] = g;
      tbl_source[s] = src;
      tbl_rx[s] = '0;
    end
    if (tbl_rx[s][idx]) begin
      tbl_rx[s] = '0;
      st = fpr_pkg::ST_PENDING_DUP;
    end
    if (idx == 0 && tbl_rx[s] == 0) begin
      tbl_len[s] = fb[15:8];
      shift = 1 + fb[15:8] / 7;
      tbl_want[s] = (shift >= 32) ? 32'hFFFF_FFFF : ((32'd1 << shift) - 1);
    end
    chunk_mem[s][idx] = (idx == 0) ? {8'h00, fb[63:16]} : fb[63:8];
    tbl_rx[s][idx] = 1'b1;
    if (tbl_rx[s] != tbl_want[s]) begin
      pending_results.push_back(mk_result(st, s, '0, '0, '0, 1'b1));
      return;
    end
    last_f = 0;
    for (f = 0; f < FRAMES; f++)
      if (tbl_rx[s][f]) last_f = f;
    for (f = 0; f < FRAMES; f++)
      if (tbl_rx[s][f])
        pending_results.push_back(mk_result(fpr_pkg::ST_COMPLETE, s, f[4:0],
                                            chunk_mem[s][f],
                                            (f == 0) ? 3'd6 : 3'd7, f == last_f));
    tbl_busy[s] = 1'b0;
    tbl_rx[s] = '0;
  endfunction

  // result checker; the receiver cannot stall so every strobe is taken
  always @(posedge clk) begin
    frag_result_t e;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: status %0d slot %0d index %0d", status,
                   slot_number, chunk_index);
      end else begin
        e = pending_results.pop_front();
        if (status == fpr_pkg::ST_COMPLETE && last_chunk) packets_done++;
        if (status == fpr_pkg::ST_DROPPED) drops_seen++;
        if (status == fpr_pkg::ST_PENDING_DUP) restarts_seen++;
        if (status !== e.status || slot_number !== e.slot || packet_group !== e.group ||
            packet_source !== e.source || packet_size !== e.size ||
            chunk_index !== e.index || chunk_data !== e.data ||
            chunk_bytes !== e.nbytes || last_chunk !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch exp: st %0d slot %0d grp %h src %h size %0d ",
                     e.status, e.slot, e.group, e.source, e.size,
                     "idx %0d data %h nb %0d last %0d",
                     e.index, e.data, e.nbytes, e.last);
            $display("         got: st %0d slot %0d grp %h src %h size %0d ",
                     status, slot_number, packet_group, packet_source, packet_size,
                     "idx %0d data %h nb %0d last %0d",
                     chunk_index, chunk_data, chunk_bytes, last_chunk);
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One request: drive, wait for acceptance, predict, then maybe idle.
  task automatic send_frame(logic [17:0] g, logic [7:0] src, logic [63:0] fb);
    int gap;
    start <= 1'b1;
    group_number <= g;
    source_address <= src;
    frame_bytes <= fb;
    @(posedge clk);
    while (busy) @(posedge clk);
    reassemble(g, src, fb);
    frames_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  function automatic logic [63:0] make_frame(logic [4:0] idx, logic [7:0] len);
    logic [63:0] fb;
    fb = {$urandom, $urandom};
    fb[4:0] = idx;
    if (idx == 0) fb[15:8] = len;
    return fb;
  endfunction

  task automatic test_directed();
    logic [63:0] fb;
    // all-ones key, frame index 6 (stays pending), then a single-frame packet with the all-zeros key
    send_frame(18'h3FFFF, 8'hFF, {56'hFF_FFFF_FFFF_FFFF, 8'h06} | 64'hE0);
    send_frame(18'h00000, 8'h00, 64'h0000_0000_0000_0600);
    // two frames, length 7, second frame first
    send_frame(18'h12345, 8'h21, make_frame(5'd1, 8'd0));
    send_frame(18'h12345, 8'h21, make_frame(5'd0, 8'd7));
    // fresh slot, frame 0 then 1: frame 0 loads the length and expected mask
    send_frame(18'h2AAAA, 8'h55, make_frame(5'd0, 8'd13));
    send_frame(18'h2AAAA, 8'h55, make_frame(5'd1, 8'd0));
    // duplicate restart on frame 1, then duplicate frame 0 reloads length
    send_frame(18'h15555, 8'hAA, make_frame(5'd0, 8'd20));
    send_frame(18'h15555, 8'hAA, make_frame(5'd1, 8'd0));
    send_frame(18'h15555, 8'hAA, make_frame(5'd1, 8'd0));
    send_frame(18'h15555, 8'hAA, make_frame(5'd0, 8'd20));
    send_frame(18'h15555, 8'hAA, make_frame(5'd0, 8'd3));
    settle();
    // 32 frames of one key, frame 0 last; its length is not loaded, so all stay pending
    for (int f = 1; f < FRAMES; f++) begin
      fb = (f % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;
      fb[4:0] = f[4:0];
      send_frame(18'h3C3C3, 8'h81, fb);
    end
    send_frame(18'h3C3C3, 8'h81, make_frame(5'd0, 8'd255));
    settle();
  endtask

  // fill every free slot, drop the frames that find none, then free the filled slots again
  task automatic test_slot_exhaustion();
    for (int k = 0; k < SLOTS; k++)
      send_frame(18'(18'h20000 + k), 8'h5A, make_frame(5'd0, 8'd255));
    send_frame(18'h3FFFF, 8'h5A, make_frame(5'd2, 8'd0));
    settle();
    for (int k = 0; k < SLOTS; k++)
      send_frame(18'(18'h20000 + k), 8'h5A, make_frame(5'd0, 8'd0));
    settle();
  endtask

  task automatic test_random_traffic(int target);
    logic [17:0] groups [6];
    logic [7:0]  sources [4];
    logic [17:0] g;
    logic [7:0]  src;
    logic [7:0]  len;
    int order [$];
    int nframes;
    int j;
    int tmp;
    int stop_at;
    stop_at = frames_sent + target;
    foreach (groups[k]) groups[k] = 18'($urandom);
    foreach (sources[k]) sources[k] = 8'($urandom);
    while (frames_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        send_frame(18'($urandom), 8'($urandom), {$urandom, $urandom});
      end else begin
        g = groups[$urandom_range(0, 5)];
        src = sources[$urandom_range(0, 3)];
        len = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
        nframes = (len / 7 + 1 > FRAMES) ? FRAMES : len / 7 + 1;
        order.delete();
        for (int f = 1; f < nframes; f++) order.push_back(f);
        for (int k = order.size() - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k]; order[k] = order[j]; order[j] = tmp;
        end
        if ($urandom_range(0, 9) == 0) order.insert($urandom_range(0, order.size()), 0);
        else order.push_front(0);
        if ($urandom_range(0, 9) == 0 && order.size() > 1)
          order.insert($urandom_range(1, order.size()),
                       order[$urandom_range(0, order.size() - 1)]);
        foreach (order[k]) send_frame(g, src, make_frame(order[k][4:0], len));
      end
      if ($urandom_range(0, 39) == 0) settle();
    end
    settle();
  endtask

  initial begin
    for (int k = 0; k < SLOTS; k++) begin
      tbl_busy[k] = 1'b0; tbl_group[k] = '0; tbl_source[k] = '0;
      tbl_rx[k] = '0; tbl_want[k] = '0; tbl_len[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_slot_exhaustion();
    test_random_traffic(310 - frames_sent);
    $display("Sent %0d frames: %0d packets completed, %0d drops, %0d restarts",
             frames_sent, packets_done, drops_seen, restarts_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/fpr_pkg.sv
sv/fpr_ctrl.sv
sv/fpr_datapath.sv
sv/fast_packet_reassembly_top.sv
tb/testbench.sv
